FILE: design/ehg_pkg.sv
package ehg_pkg;

  localparam int ANG_W  = 16;
  localparam int PCT_W  = 24;
  localparam int E_W    = 17;  // eye position after the vertical offset
  localparam int KNEE_W = 18;
  localparam int XD_W   = 19;  // excess, slope divisor and slope numerators
  localparam int PROD_W = 2 * XD_W;
  localparam int SUM_W  = PROD_W + 2;
  localparam int CFG_IDX_W = 3;

  localparam logic [CFG_IDX_W-1:0] REG_THR_H  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_EMAX_H = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_GMAX_H = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_THR_V  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_EMAX_V = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_GMAX_V = 3'd5;

  localparam logic signed [ANG_W-1:0] THR_H_RST  = 16'sd2560;
  localparam logic signed [ANG_W-1:0] EMAX_H_RST = 16'sd7680;
  localparam logic signed [ANG_W-1:0] GMAX_H_RST = 16'sd23040;
  localparam logic signed [ANG_W-1:0] THR_V_RST  = 16'sd2560;
  localparam logic signed [ANG_W-1:0] EMAX_V_RST = 16'sd6656;
  localparam logic signed [ANG_W-1:0] GMAX_V_RST = 16'sd17920;

  localparam logic signed [ANG_W-1:0] ANG_MAX = 16'sh7fff;
  localparam logic signed [ANG_W-1:0] ANG_MIN = 16'sh8000;
  localparam logic signed [PCT_W-1:0] PCT_MAX = 24'sh7fffff;
  localparam logic signed [PCT_W-1:0] PCT_MIN = 24'sh800000;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_DIV_ZERO  = 2'd1,
    ST_GAZE_ZERO = 2'd2
  } status_t;

  typedef struct packed {
    logic                    axis;
    logic signed [ANG_W-1:0] gaze;
    logic signed [ANG_W-1:0] eye_start;
  } req_t;

  typedef struct packed {
    logic signed [ANG_W-1:0] eye_amount;
    logic signed [ANG_W-1:0] head_amount;
    logic signed [PCT_W-1:0] eye_percent;
    logic signed [PCT_W-1:0] head_percent;
    logic [1:0]              status;
  } rsp_t;

  typedef struct packed {
    logic signed [ANG_W-1:0] thr_h;
    logic signed [ANG_W-1:0] emax_h;
    logic signed [ANG_W-1:0] gmax_h;
    logic signed [ANG_W-1:0] thr_v;
    logic signed [ANG_W-1:0] emax_v;
    logic signed [ANG_W-1:0] gmax_v;
  } cfg_t;

  // sideband through the slope divider
  typedef struct packed {
    logic signed [ANG_W-1:0]  gaze;
    logic signed [KNEE_W-1:0] knee;
    logic                     s_eye;
    logic                     s_head;
    logic                     above;
    logic                     dzero;
  } p1_t;

  // sideband through the percent divider
  typedef struct packed {
    logic signed [ANG_W-1:0] eye;
    logic signed [ANG_W-1:0] head;
    logic                    s_eye;
    logic                    s_head;
    status_t                 status;
  } p2_t;

  function automatic logic signed [ANG_W-1:0] sat_ang(input logic signed [SUM_W-1:0] v);
    logic signed [ANG_W-1:0] r;
    r = ANG_W'(v);
    if (v > SUM_W'(ANG_MAX)) r = ANG_MAX;
    else if (v < SUM_W'(ANG_MIN)) r = ANG_MIN;
    return r;
  endfunction

endpackage

FILE: design/ehg_div.sv
// Pipelined restoring divider: one quotient bit per stage, two numerators
// sharing one divisor, sideband carried alongside.
module ehg_div #(
  parameter int NW = 38,
  parameter int DW = 19,
  parameter int PW = 8
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          en,
  input  logic          in_valid,
  input  logic [NW-1:0] n0,
  input  logic [NW-1:0] n1,
  input  logic [DW-1:0] den,
  input  logic [PW-1:0] pay,
  output logic          out_valid,
  output logic [NW-1:0] q0,
  output logic [NW-1:0] q1,
  output logic [PW-1:0] out_pay
);

  logic          v   [0:NW];
  logic [DW-1:0] r0  [0:NW];
  logic [DW-1:0] r1  [0:NW];
  logic [NW-1:0] a0  [0:NW];
  logic [NW-1:0] a1  [0:NW];
  logic [DW-1:0] dv  [0:NW];
  logic [PW-1:0] pl  [0:NW];

  assign v[0]  = in_valid;
  assign r0[0] = '0;
  assign r1[0] = '0;
  assign a0[0] = n0;
  assign a1[0] = n1;
  assign dv[0] = den;
  assign pl[0] = pay;

  for (genvar i = 0; i < NW; i++) begin : g_stage
    logic [DW:0] t0, t1;
    logic        ge0, ge1;

    always_comb begin
      t0  = {r0[i], a0[i][NW-1]};
      t1  = {r1[i], a1[i][NW-1]};
      ge0 = t0 >= {1'b0, dv[i]};
      ge1 = t1 >= {1'b0, dv[i]};
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        v[i+1] <= 1'b0;
      end else if (en) begin
        v[i+1] <= v[i];
      end
      if (en) begin
        r0[i+1] <= ge0 ? DW'(t0 - {1'b0, dv[i]}) : DW'(t0);
        r1[i+1] <= ge1 ? DW'(t1 - {1'b0, dv[i]}) : DW'(t1);
        a0[i+1] <= {a0[i][NW-2:0], ge0};
        a1[i+1] <= {a1[i][NW-2:0], ge1};
        dv[i+1] <= dv[i];
        pl[i+1] <= pl[i];
      end
    end
  end

  assign out_valid = v[NW];
  assign q0        = a0[NW];
  assign q1        = a1[NW];
  assign out_pay   = pl[NW];

endmodule

FILE: design/ehg_front.sv
// Knee, excess and slope terms, products, then magnitudes for the divider.
module ehg_front import ehg_pkg::*; #(
  parameter int FRAC = 8
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  logic              in_valid,
  input  req_t              req,
  input  cfg_t              cfg,
  output logic              out_valid,
  output logic [PROD_W-1:0] n_eye,
  output logic [PROD_W-1:0] n_head,
  output logic [XD_W-1:0]   den,
  output p1_t               pay
);

  localparam logic signed [E_W-1:0] VOFF = E_W'(8 << FRAC);

  // stage A
  logic                    a_v;
  logic signed [ANG_W-1:0] a_gaze, a_thr, a_emax, a_gmax;
  logic signed [E_W-1:0]   a_e;
  // stage B
  logic                     b_v;
  logic signed [ANG_W-1:0]  b_gaze;
  logic signed [KNEE_W-1:0] b_knee;
  logic signed [XD_W-1:0]   b_x, b_d, b_a, b_b;
  // stage C
  logic                     c_v, c_above;
  logic signed [ANG_W-1:0]  c_gaze;
  logic signed [KNEE_W-1:0] c_knee;
  logic signed [XD_W-1:0]   c_d;
  logic signed [PROD_W-1:0] c_pa, c_pb;

  logic signed [E_W-1:0]    e_adj;
  logic signed [KNEE_W-1:0] knee;

  always_comb begin
    e_adj = E_W'(req.eye_start) - (req.axis ? VOFF : E_W'(0));
    knee  = KNEE_W'(a_thr) + KNEE_W'(a_e);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_v <= 1'b0;
      b_v <= 1'b0;
      c_v <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      a_v <= in_valid;
      b_v <= a_v;
      c_v <= b_v;
      out_valid <= c_v;
    end
    if (en) begin
      a_gaze <= req.gaze;
      a_e    <= e_adj;
      a_thr  <= req.axis ? cfg.thr_v  : cfg.thr_h;
      a_emax <= req.axis ? cfg.emax_v : cfg.emax_h;
      a_gmax <= req.axis ? cfg.gmax_v : cfg.gmax_h;

      b_gaze <= a_gaze;
      b_knee <= knee;
      b_x    <= XD_W'(a_gaze) - XD_W'(knee);
      b_d    <= XD_W'(a_gmax) - XD_W'(a_thr) - XD_W'(a_e);
      b_a    <= XD_W'(a_emax) - XD_W'(a_thr);
      b_b    <= XD_W'(a_gmax) - XD_W'(a_e) - XD_W'(a_emax);

      c_gaze  <= b_gaze;
      c_knee  <= b_knee;
      c_d     <= b_d;
      c_above <= KNEE_W'(b_gaze) > b_knee;
      c_pa    <= PROD_W'(b_a) * PROD_W'(b_x);
      c_pb    <= PROD_W'(b_b) * PROD_W'(b_x);

      n_eye      <= c_pa[PROD_W-1] ? PROD_W'(-c_pa) : PROD_W'(c_pa);
      n_head     <= c_pb[PROD_W-1] ? PROD_W'(-c_pb) : PROD_W'(c_pb);
      den        <= c_d[XD_W-1] ? XD_W'(-c_d) : XD_W'(c_d);
      pay.gaze   <= c_gaze;
      pay.knee   <= c_knee;
      pay.s_eye  <= c_pa[PROD_W-1] ^ c_d[XD_W-1];
      pay.s_head <= c_pb[PROD_W-1] ^ c_d[XD_W-1];
      pay.above  <= c_above;
      pay.dzero  <= c_d == '0;
    end
  end

endmodule

FILE: design/ehg_mid.sv
// Signed amounts with saturation and status, then percent numerators.
module ehg_mid import ehg_pkg::*; #(
  parameter int FRAC = 8,
  parameter int KW   = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  en,
  input  logic                  in_valid,
  input  logic [PROD_W-1:0]     q_eye,
  input  logic [PROD_W-1:0]     q_head,
  input  p1_t                   in_pay,
  output logic                  out_valid,
  output logic [ANG_W+KW-1:0]   n_eye,
  output logic [ANG_W+KW-1:0]   n_head,
  output logic [ANG_W-1:0]      den,
  output p2_t                   pay
);

  localparam int NW = ANG_W + KW;
  localparam logic signed [KW-1:0] KS = KW'(100 << FRAC);

  logic signed [PROD_W:0]  qe, qh;
  logic signed [ANG_W-1:0] eye_c, head_c;
  status_t                 st;

  // stage E
  logic                    e_v;
  logic signed [ANG_W-1:0] e_eye, e_head, e_gaze;
  status_t                 e_st;
  // stage F
  logic                    f_v;
  logic signed [NW-1:0]    f_pe, f_ph;
  logic signed [ANG_W-1:0] f_eye, f_head, f_gaze;
  status_t                 f_st;

  always_comb begin
    qe = in_pay.s_eye  ? -$signed({1'b0, q_eye})  : $signed({1'b0, q_eye});
    qh = in_pay.s_head ? -$signed({1'b0, q_head}) : $signed({1'b0, q_head});
    eye_c  = in_pay.gaze;
    head_c = '0;
    st     = ST_OK;
    if (in_pay.above) begin
      if (in_pay.dzero) begin
        eye_c = '0;
        st    = ST_DIV_ZERO;
      end else begin
        eye_c  = sat_ang(SUM_W'(in_pay.knee) + SUM_W'(qe));
        head_c = sat_ang(SUM_W'(qh));
      end
    end
    if (st == ST_OK && in_pay.gaze == '0) st = ST_GAZE_ZERO;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      e_v <= 1'b0;
      f_v <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      e_v <= in_valid;
      f_v <= e_v;
      out_valid <= f_v;
    end
    if (en) begin
      e_eye  <= eye_c;
      e_head <= head_c;
      e_gaze <= in_pay.gaze;
      e_st   <= st;

      f_pe   <= NW'(e_eye) * NW'(KS);
      f_ph   <= NW'(e_head) * NW'(KS);
      f_eye  <= e_eye;
      f_head <= e_head;
      f_gaze <= e_gaze;
      f_st   <= e_st;

      n_eye      <= f_pe[NW-1] ? NW'(-f_pe) : NW'(f_pe);
      n_head     <= f_ph[NW-1] ? NW'(-f_ph) : NW'(f_ph);
      den        <= f_gaze[ANG_W-1] ? ANG_W'(-f_gaze) : ANG_W'(f_gaze);
      pay.eye    <= f_eye;
      pay.head   <= f_head;
      pay.s_eye  <= f_pe[NW-1] ^ f_gaze[ANG_W-1];
      pay.s_head <= f_ph[NW-1] ^ f_gaze[ANG_W-1];
      pay.status <= f_st;
    end
  end

endmodule

FILE: design/ehg_fin.sv
// Signed percentages, saturated; zeroed whenever status is not ok.
module ehg_fin import ehg_pkg::*; #(
  parameter int NW = 32
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          en,
  input  logic          in_valid,
  input  logic [NW-1:0] q_eye,
  input  logic [NW-1:0] q_head,
  input  p2_t           in_pay,
  output logic          out_valid,
  output rsp_t          out_data
);

  logic signed [NW:0]      ve, vh;
  logic signed [PCT_W-1:0] pe, ph;

  function automatic logic signed [PCT_W-1:0] sat_pct(input logic signed [NW:0] v);
    logic signed [PCT_W-1:0] r;
    r = PCT_W'(v);
    if (v > (NW+1)'(PCT_MAX)) r = PCT_MAX;
    else if (v < (NW+1)'(PCT_MIN)) r = PCT_MIN;
    return r;
  endfunction

  always_comb begin
    ve = in_pay.s_eye  ? -$signed({1'b0, q_eye})  : $signed({1'b0, q_eye});
    vh = in_pay.s_head ? -$signed({1'b0, q_head}) : $signed({1'b0, q_head});
    pe = sat_pct(ve);
    ph = sat_pct(vh);
    if (in_pay.status != ST_OK) begin
      pe = '0;
      ph = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
    if (en) begin
      out_data.eye_amount   <= in_pay.eye;
      out_data.head_amount  <= in_pay.head;
      out_data.eye_percent  <= pe;
      out_data.head_percent <= ph;
      out_data.status       <= in_pay.status;
    end
  end

endmodule

FILE: design/eye_head_gaze_split_top.sv
// Request to response: front, 38 slope divider stages, mid, NW2 percent stages, fin, output register,
// with NW2 = 17 + bits of 100 << FRAC.
// Throughput: one request per cycle while req_stall is low; both dividers retire one quotient bit per stage.
// A one-entry skid buffer behind the output register absorbs a stalled response.
// Reset (synchronous, active high) clears all valid bits and loads the default limits.
module eye_head_gaze_split_top import ehg_pkg::*; #(
  parameter int ANGLE_FRAC_BITS = 8
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 req_valid,
  output logic                 req_stall,
  input  req_t                 req,
  output logic                 rsp_valid,
  input  logic                 rsp_stall,
  output rsp_t                 rsp,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [ANG_W-1:0]     cfg_data
);

  localparam int KW  = $clog2((100 << ANGLE_FRAC_BITS) + 1) + 1;
  localparam int NW2 = ANG_W + KW;

  cfg_t cfg;
  logic en;

  logic              f_v;
  logic [PROD_W-1:0] f_ne, f_nh;
  logic [XD_W-1:0]   f_den;
  p1_t               f_pay, d1_pay;
  logic              d1_v;
  logic [PROD_W-1:0] d1_qe, d1_qh;

  logic              m_v;
  logic [NW2-1:0]    m_ne, m_nh;
  logic [ANG_W-1:0]  m_den;
  p2_t               m_pay, d2_pay;
  logic              d2_v;
  logic [NW2-1:0]    d2_qe, d2_qh;

  logic core_v;
  rsp_t core_data;
  logic skid_valid;
  rsp_t skid;

  assign cfg_ready = 1'b1;
  assign en        = !skid_valid;
  assign req_stall = skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.thr_h  <= THR_H_RST;
      cfg.emax_h <= EMAX_H_RST;
      cfg.gmax_h <= GMAX_H_RST;
      cfg.thr_v  <= THR_V_RST;
      cfg.emax_v <= EMAX_V_RST;
      cfg.gmax_v <= GMAX_V_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_THR_H:  cfg.thr_h  <= cfg_data;
        REG_EMAX_H: cfg.emax_h <= cfg_data;
        REG_GMAX_H: cfg.gmax_h <= cfg_data;
        REG_THR_V:  cfg.thr_v  <= cfg_data;
        REG_EMAX_V: cfg.emax_v <= cfg_data;
        REG_GMAX_V: cfg.gmax_v <= cfg_data;
        default: ;
      endcase
    end
  end

  ehg_front #(.FRAC(ANGLE_FRAC_BITS)) u_front (
    .clk(clk), .rst(rst), .en(en), .in_valid(req_valid && !req_stall), .req(req), .cfg(cfg),
    .out_valid(f_v), .n_eye(f_ne), .n_head(f_nh), .den(f_den), .pay(f_pay)
  );

  ehg_div #(.NW(PROD_W), .DW(XD_W), .PW($bits(p1_t))) u_div_slope (
    .clk(clk), .rst(rst), .en(en), .in_valid(f_v), .n0(f_ne), .n1(f_nh), .den(f_den),
    .pay(f_pay), .out_valid(d1_v), .q0(d1_qe), .q1(d1_qh), .out_pay(d1_pay)
  );

  ehg_mid #(.FRAC(ANGLE_FRAC_BITS), .KW(KW)) u_mid (
    .clk(clk), .rst(rst), .en(en), .in_valid(d1_v), .q_eye(d1_qe), .q_head(d1_qh),
    .in_pay(d1_pay), .out_valid(m_v), .n_eye(m_ne), .n_head(m_nh), .den(m_den), .pay(m_pay)
  );

  ehg_div #(.NW(NW2), .DW(ANG_W), .PW($bits(p2_t))) u_div_pct (
    .clk(clk), .rst(rst), .en(en), .in_valid(m_v), .n0(m_ne), .n1(m_nh), .den(m_den),
    .pay(m_pay), .out_valid(d2_v), .q0(d2_qe), .q1(d2_qh), .out_pay(d2_pay)
  );

  ehg_fin #(.NW(NW2)) u_fin (
    .clk(clk), .rst(rst), .en(en), .in_valid(d2_v), .q_eye(d2_qe), .q_head(d2_qh),
    .in_pay(d2_pay), .out_valid(core_v), .out_data(core_data)
  );

  // core advances only while the skid entry is empty
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (rsp_valid && rsp_stall) begin
      if (core_v && en) begin
        skid       <= core_data;
        skid_valid <= 1'b1;
      end
    end else if (skid_valid) begin
      rsp        <= skid;
      rsp_valid  <= 1'b1;
      skid_valid <= 1'b0;
    end else begin
      rsp       <= core_data;
      rsp_valid <= core_v;
    end
  end

endmodule

FILE: design/ehg_chk.sv
module ehg_chk import ehg_pkg::*; (
  input logic clk,
  input logic rst,
  input logic rsp_valid,
  input logic rsp_stall,
  input rsp_t rsp
);

  a_hold_valid: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_stall |=> rsp_valid)
    else $error("response dropped while stalled");

  a_hold_data: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_stall |=> $stable(rsp))
    else $error("response changed while stalled");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> rsp.status == ST_OK || rsp.status == ST_DIV_ZERO
                  || rsp.status == ST_GAZE_ZERO)
    else $error("bad status code");

  a_pct_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.status != ST_OK |-> rsp.eye_percent == '0 && rsp.head_percent == '0)
    else $error("percent nonzero with error status");

  a_dz_amounts: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.status == ST_DIV_ZERO |-> rsp.eye_amount == '0 && rsp.head_amount == '0)
    else $error("amounts nonzero with zero divisor");

endmodule

bind eye_head_gaze_split_top ehg_chk u_ehg_chk (
  .clk(clk), .rst(rst), .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp(rsp)
);
